// File: hdl/iir_filter_direct_form_one_assert.svh
// ----------------------------------------------------------------------------
// IIR filter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef IIR_FILTER_DIRECT_FORM_ONE_ASSERT_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_ASSERT_SVH

// same-cycle implication
`define IIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir: same-cycle check failed");

// next-cycle implication
`define IIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir: next-cycle check failed");

`endif

// File: hdl/iir_pkg.sv
// ----------------------------------------------------------------------------
// IIR filter package
// Widths, types, register codes and the configuration bundle.
// ----------------------------------------------------------------------------
package iir_pkg;

    localparam int FF_TAPS_MAX    = 3;
    localparam int FB_TAPS_MAX    = 2;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = 20;
    localparam int CNT_BITS       = 2;
    localparam int ADDR_BITS      = 5;
    localparam int REG_IDX_BITS   = ADDR_BITS - 2;

    localparam int FF_HIST_DEPTH  = FF_TAPS_MAX - 1;
    localparam int FF_IDX_BITS    = $clog2(FF_TAPS_MAX);
    localparam int FB_IDX_BITS    = $clog2(FB_TAPS_MAX);

    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = PROD_BITS + $clog2(FF_TAPS_MAX + FB_TAPS_MAX);
    localparam int QUOT_BITS      = ACC_BITS - COEF_FRAC_BITS;

    localparam int SAMPLE_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN     = -(2 ** (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic        [CNT_BITS-1:0]    cnt_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic signed [QUOT_BITS-1:0]   quot_t;

    localparam acc_t ROUND_HALF = acc_t'(1) << (COEF_FRAC_BITS - 1);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FF_TAP_COUNT,
        REG_FB_TAP_COUNT,
        REG_FF_COEF_0,
        REG_FF_COEF_1,
        REG_FF_COEF_2,
        REG_FB_COEF_0,
        REG_FB_COEF_1
    } reg_idx_t;

    typedef struct packed {
        cnt_t                     ff_cnt;
        cnt_t                     fb_cnt;
        coef_t [FF_TAPS_MAX-1:0]  ff_coef;
        coef_t [FB_TAPS_MAX-1:0]  fb_coef;
    } cfg_t;

    typedef struct packed {
        logic stage_valid;
        logic stage_last;
        logic advance;
        logic hist_clear;
    } stat_t;

endpackage

// File: hdl/iir_in_if.sv
// ----------------------------------------------------------------------------
// IIR input stream interface
// valid/ready channel carrying one input sample per beat.
// ----------------------------------------------------------------------------
interface iir_in_if;
    logic             valid;
    logic             ready;
    iir_pkg::sample_t sample_in;
    logic             last_sample;

    modport source (output valid, output sample_in, output last_sample, input ready);
    modport sink   (input valid, input sample_in, input last_sample, output ready);
endinterface

// File: hdl/iir_out_if.sv
// ----------------------------------------------------------------------------
// IIR output stream interface
// valid/ready channel carrying one filtered sample per beat.
// ----------------------------------------------------------------------------
interface iir_out_if;
    logic             valid;
    logic             ready;
    iir_pkg::sample_t sample_out;
    logic             last_out;
    logic             saturated;

    modport source (output valid, output sample_out, output last_out, output saturated,
                    input ready);
    modport sink   (input valid, input sample_out, input last_out, input saturated,
                    output ready);
endinterface

// File: hdl/iir_cfg.sv
// ----------------------------------------------------------------------------
// IIR configuration registers
// APB-style register file for tap counts and coefficients.
// ----------------------------------------------------------------------------
module iir_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iir_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output iir_pkg::cfg_t                  cfg
);

    iir_pkg::cfg_t     cfg_reg;
    iir_pkg::cfg_t     cfg_next;
    iir_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = iir_pkg::reg_idx_t'(paddr[iir_pkg::ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                iir_pkg::REG_FF_TAP_COUNT: cfg_next.ff_cnt = pwdata[iir_pkg::CNT_BITS-1:0];
                iir_pkg::REG_FB_TAP_COUNT: cfg_next.fb_cnt = pwdata[iir_pkg::CNT_BITS-1:0];
                iir_pkg::REG_FF_COEF_0:
                    cfg_next.ff_coef[0] = pwdata[iir_pkg::COEF_BITS-1:0];
                iir_pkg::REG_FF_COEF_1:
                    cfg_next.ff_coef[1] = pwdata[iir_pkg::COEF_BITS-1:0];
                iir_pkg::REG_FF_COEF_2:
                    cfg_next.ff_coef[2] = pwdata[iir_pkg::COEF_BITS-1:0];
                iir_pkg::REG_FB_COEF_0:
                    cfg_next.fb_coef[0] = pwdata[iir_pkg::COEF_BITS-1:0];
                iir_pkg::REG_FB_COEF_1:
                    cfg_next.fb_coef[1] = pwdata[iir_pkg::COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back, coefficients sign-extended
    always_comb
    begin
        unique case (reg_idx)
            iir_pkg::REG_FF_TAP_COUNT: prdata = 32'(cfg_reg.ff_cnt);
            iir_pkg::REG_FB_TAP_COUNT: prdata = 32'(cfg_reg.fb_cnt);
            iir_pkg::REG_FF_COEF_0:    prdata = 32'($signed(cfg_reg.ff_coef[0]));
            iir_pkg::REG_FF_COEF_1:    prdata = 32'($signed(cfg_reg.ff_coef[1]));
            iir_pkg::REG_FF_COEF_2:    prdata = 32'($signed(cfg_reg.ff_coef[2]));
            iir_pkg::REG_FB_COEF_0:    prdata = 32'($signed(cfg_reg.fb_coef[0]));
            iir_pkg::REG_FB_COEF_1:    prdata = 32'($signed(cfg_reg.fb_coef[1]));
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ff_cnt:  iir_pkg::cnt_t'(1),
                         fb_cnt:  iir_pkg::cnt_t'(1),
                         ff_coef: '0,
                         fb_coef: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/iir_mac.sv
// ----------------------------------------------------------------------------
// IIR multiply-accumulate
// Tap select, parallel products, sum, round half up and saturate.
// ----------------------------------------------------------------------------
module iir_mac
(
    input  iir_pkg::cfg_t                                    cfg,
    input  iir_pkg::sample_t                                 cur,
    input  iir_pkg::sample_t [iir_pkg::FF_HIST_DEPTH-1:0]    x_hist,
    input  iir_pkg::sample_t [iir_pkg::FB_TAPS_MAX-1:0]      y_hist,
    output iir_pkg::sample_t                                 y,
    output logic                                             sat
);

    iir_pkg::cnt_t                                  n_taps;
    iir_pkg::cnt_t                                  m_taps;
    iir_pkg::sample_t [iir_pkg::FF_TAPS_MAX-1:0]    x_taps;
    iir_pkg::sample_t [iir_pkg::FF_TAPS_MAX-1:0]    ff_op;
    iir_pkg::sample_t [iir_pkg::FB_TAPS_MAX-1:0]    fb_op;
    iir_pkg::prod_t   [iir_pkg::FF_TAPS_MAX-1:0]    ff_prod;
    iir_pkg::prod_t   [iir_pkg::FB_TAPS_MAX-1:0]    fb_prod;
    iir_pkg::acc_t                                  acc;
    iir_pkg::acc_t                                  rounded;
    iir_pkg::quot_t                                 quot;

    // count 0 acts as 1, above max acts as max
    always_comb
    begin
        if (cfg.ff_cnt == '0)
            n_taps = iir_pkg::cnt_t'(1);
        else if (cfg.ff_cnt > iir_pkg::cnt_t'(iir_pkg::FF_TAPS_MAX))
            n_taps = iir_pkg::cnt_t'(iir_pkg::FF_TAPS_MAX);
        else
            n_taps = cfg.ff_cnt;

        if (cfg.fb_cnt == '0)
            m_taps = iir_pkg::cnt_t'(1);
        else if (cfg.fb_cnt > iir_pkg::cnt_t'(iir_pkg::FB_TAPS_MAX))
            m_taps = iir_pkg::cnt_t'(iir_pkg::FB_TAPS_MAX);
        else
            m_taps = cfg.fb_cnt;
    end

    // x_taps[a] is the input of age a
    always_comb
    begin
        x_taps[0] = cur;
        for (int a = 1; a < iir_pkg::FF_TAPS_MAX; a++)
            x_taps[a] = x_hist[a-1];
    end

    // coefficient k pairs with age n-1-k (ff) and m-k (fb)
    always_comb
    begin
        for (int k = 0; k < iir_pkg::FF_TAPS_MAX; k++)
        begin
            if (iir_pkg::cnt_t'(k) < n_taps)
                ff_op[k] = x_taps[iir_pkg::FF_IDX_BITS'(n_taps - iir_pkg::cnt_t'(1)
                                                        - iir_pkg::cnt_t'(k))];
            else
                ff_op[k] = '0;
            ff_prod[k] = $signed(ff_op[k]) * $signed(cfg.ff_coef[k]);
        end
        for (int k = 0; k < iir_pkg::FB_TAPS_MAX; k++)
        begin
            if (iir_pkg::cnt_t'(k) < m_taps)
                fb_op[k] = y_hist[iir_pkg::FB_IDX_BITS'(m_taps - iir_pkg::cnt_t'(1)
                                                        - iir_pkg::cnt_t'(k))];
            else
                fb_op[k] = '0;
            fb_prod[k] = $signed(fb_op[k]) * $signed(cfg.fb_coef[k]);
        end
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < iir_pkg::FF_TAPS_MAX; k++)
            acc = acc + iir_pkg::acc_t'($signed(ff_prod[k]));
        for (int k = 0; k < iir_pkg::FB_TAPS_MAX; k++)
            acc = acc + iir_pkg::acc_t'($signed(fb_prod[k]));
    end

    // add half, floor by dropping fraction bits
    assign rounded = acc + iir_pkg::ROUND_HALF;
    assign quot    = rounded[iir_pkg::ACC_BITS-1:iir_pkg::COEF_FRAC_BITS];

    always_comb
    begin
        if (quot > iir_pkg::quot_t'(iir_pkg::SAMPLE_MAX))
        begin
            y   = iir_pkg::sample_t'(iir_pkg::SAMPLE_MAX);
            sat = 1'b1;
        end
        else if (quot < iir_pkg::quot_t'(iir_pkg::SAMPLE_MIN))
        begin
            y   = iir_pkg::sample_t'(iir_pkg::SAMPLE_MIN);
            sat = 1'b1;
        end
        else
        begin
            y   = quot[iir_pkg::SAMPLE_BITS-1:0];
            sat = 1'b0;
        end
    end

endmodule

// File: hdl/iir_core.sv
// ----------------------------------------------------------------------------
// IIR datapath core
// Input register, tap history, MAC and result register with flow control.
// ----------------------------------------------------------------------------
module iir_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  iir_pkg::cfg_t   cfg,
    iir_in_if.sink          feed,
    iir_out_if.source       result,
    output iir_pkg::stat_t  stat
);

    logic                                           stage_valid_reg;
    logic                                           stage_valid_next;
    iir_pkg::sample_t                               stage_sample_reg;
    logic                                           stage_last_reg;
    logic                                           out_valid_reg;
    logic                                           out_valid_next;
    iir_pkg::sample_t                               out_sample_reg;
    logic                                           out_last_reg;
    logic                                           out_sat_reg;
    iir_pkg::sample_t [iir_pkg::FF_HIST_DEPTH-1:0]  x_hist_reg;
    iir_pkg::sample_t [iir_pkg::FF_HIST_DEPTH-1:0]  x_hist_next;
    iir_pkg::sample_t [iir_pkg::FB_TAPS_MAX-1:0]    y_hist_reg;
    iir_pkg::sample_t [iir_pkg::FB_TAPS_MAX-1:0]    y_hist_next;
    iir_pkg::sample_t                               mac_y;
    logic                                           mac_sat;
    logic                                           out_free;
    logic                                           advance;
    logic                                           accept;
    logic                                           hist_clear;

    iir_mac u_mac
    (
        .cfg    (cfg),
        .cur    (stage_sample_reg),
        .x_hist (x_hist_reg),
        .y_hist (y_hist_reg),
        .y      (mac_y),
        .sat    (mac_sat)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = stage_valid_reg && out_free;
    assign feed.ready = !stage_valid_reg || advance;
    assign accept     = feed.valid && feed.ready;

    assign stage_valid_next = accept || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && !result.ready);

    // shift histories on each computed beat, clear after a last beat
    always_comb
    begin
        x_hist_next = x_hist_reg;
        y_hist_next = y_hist_reg;
        if (advance)
        begin
            if (stage_last_reg)
            begin
                x_hist_next = '0;
                y_hist_next = '0;
            end
            else
            begin
                for (int i = iir_pkg::FF_HIST_DEPTH - 1; i > 0; i--)
                    x_hist_next[i] = x_hist_reg[i-1];
                x_hist_next[0] = stage_sample_reg;
                for (int i = iir_pkg::FB_TAPS_MAX - 1; i > 0; i--)
                    y_hist_next[i] = y_hist_reg[i-1];
                y_hist_next[0] = mac_y;
            end
        end
    end

    always_comb
    begin
        hist_clear = 1'b1;
        for (int i = 0; i < iir_pkg::FF_HIST_DEPTH; i++)
            if (x_hist_reg[i] != '0)
                hist_clear = 1'b0;
        for (int i = 0; i < iir_pkg::FB_TAPS_MAX; i++)
            if (y_hist_reg[i] != '0)
                hist_clear = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            x_hist_reg      <= '0;
            y_hist_reg      <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            x_hist_reg      <= x_hist_next;
            y_hist_reg      <= y_hist_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_sample_reg <= feed.sample_in;
            stage_last_reg   <= feed.last_sample;
        end
        if (advance)
        begin
            out_sample_reg <= mac_y;
            out_last_reg   <= stage_last_reg;
            out_sat_reg    <= mac_sat;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.last_out   = out_last_reg;
    assign result.saturated  = out_sat_reg;

    assign stat.stage_valid = stage_valid_reg;
    assign stat.stage_last  = stage_last_reg;
    assign stat.advance     = advance;
    assign stat.hist_clear  = hist_clear;

endmodule

// File: hdl/iir_filter_direct_form_one.sv
// ----------------------------------------------------------------------------
// Direct-form-I IIR filter, top level
// 24-bit signed samples, Q4.16 coefficients, rounded and saturated output.
// ----------------------------------------------------------------------------
// Usage:
//   feed   : input stream, one sample per beat (sample_in, last_sample).
//   result : output stream, one filtered sample per input beat, in order
//            (sample_out, last_out, saturated).
//   APB    : registers at byte address 4*i: ff_tap_count, fb_tap_count,
//            ff_coef_0..2, fb_coef_0..1. Write only while the stream is idle.
// Path: an input beat is held in the input register, then its result
//   in the result register.
// Throughput: 1 sample per cycle while result is not held. The five
//   products, the adder and the round/saturate sit between the input
//   register and the result register, and the output history is updated
//   at the same edge the result is registered, closing the feedback loop.
// Reset: tap counts go to 1, coefficients and history to zero, both
//   streams empty.
// Stall: a held result keeps the result register; one more beat is taken
//   into the input register, then feed.ready drops until result moves.
// A beat with last_sample set clears both histories after its result.
// ----------------------------------------------------------------------------
`include "iir_filter_direct_form_one_assert.svh"

module iir_filter_direct_form_one
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iir_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    iir_in_if.sink                         feed,
    iir_out_if.source                      result
);

    iir_pkg::cfg_t  cfg;
    iir_pkg::stat_t stat;

    // configuration register file
    iir_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sample path: input register -> MAC -> result register, history inside
    iir_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .feed   (feed),
        .result (result),
        .stat   (stat)
    );

    // a computed beat always lands in the result register
    `IIR_ASSERT_NEXT(a_advance_lands, stat.advance, result.valid)

    // histories are all zero right after a last beat is computed
    `IIR_ASSERT_NEXT(a_last_clears, stat.advance && stat.stage_last, stat.hist_clear)

    // input backpressure only when the input register is occupied
    `IIR_ASSERT_SAME(a_ready_cause, !feed.ready, stat.stage_valid)

    // a clipped result sits on one of the rails
    `IIR_ASSERT_SAME(a_sat_rail, result.valid && result.saturated,
        result.sample_out == iir_pkg::sample_t'(iir_pkg::SAMPLE_MAX) ||
        result.sample_out == iir_pkg::sample_t'(iir_pkg::SAMPLE_MIN))

endmodule
